/* sv/pcs_pkg.sv */
// ----------------------------------------------------------------------------
// Pump cascade stage sequencer package
// Shared types, codes and constants for the sequencer, its configuration
// registers, its step logic and its checker.
// ----------------------------------------------------------------------------
package pcs_pkg;

  // Field widths.
  localparam int TimeW   = 32;
  localparam int FreqW   = 12;
  localparam int CountW  = 4;
  localparam int PauseW  = 13;
  localparam int TicksW  = 20;
  localparam int CodeW   = 4;
  localparam int TrendW  = 2;
  localparam int FillW   = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 13;

  // Default for the pump limit parameter.
  localparam int MaxPumpsDefault = 8;

  // One pause unit is one hundred ticks.
  localparam logic [TicksW-1:0] TicksPerPause = TicksW'(100);
  // Fixed wait after adding a pump when at most one pump is allowed.
  localparam logic [TicksW-1:0] SingleUpWait  = TicksW'(1000);

  // Configuration register reset values.
  localparam logic [FreqW-1:0]  FreqMinReset   = FreqW'(250);
  localparam logic [FreqW-1:0]  FreqMaxReset   = FreqW'(500);
  localparam logic [CountW-1:0] PumpCountReset = CountW'(2);
  localparam logic [TicksW-1:0] PauseTicksReset = TicksW'(5000);

  // Fill routine status codes.
  localparam logic [FillW-1:0] FillDone = FillW'(1);
  localparam int FillAlarmBit = 7;

  // Trend codes of the limit check.
  localparam logic [TrendW-1:0] TrendUp   = 2'b01;
  localparam logic [TrendW-1:0] TrendDown = 2'b11;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FREQ_MIN      = 3'd0,
    CFG_FREQ_MAX      = 3'd1,
    CFG_PUMP_COUNT    = 3'd2,
    CFG_PAUSE_UP      = 3'd3,
    CFG_PAUSE_DOWN    = 3'd4,
    CFG_HANDOVER_MODE = 3'd5,
    CFG_FILL_ENABLE   = 3'd6
  } cfg_index_t;

  // State codes as shown on the result channel.
  localparam logic [CodeW-1:0] CODE_INIT  = 4'd0;
  localparam logic [CodeW-1:0] CODE_START = 4'd1;
  localparam logic [CodeW-1:0] CODE_RUN   = 4'd2;
  localparam logic [CodeW-1:0] CODE_UP    = 4'd3;
  localparam logic [CodeW-1:0] CODE_DOWN  = 4'd4;
  localparam logic [CodeW-1:0] CODE_STOP  = 4'd5;
  localparam logic [CodeW-1:0] CODE_OFF   = 4'd6;
  localparam logic [CodeW-1:0] CODE_ALARM = 4'd7;
  localparam logic [CodeW-1:0] CODE_FILL  = 4'd8;

  // Controller state, one-hot.
  typedef enum logic [8:0] {
    ST_INIT  = 9'b000000001,
    ST_START = 9'b000000010,
    ST_RUN   = 9'b000000100,
    ST_UP    = 9'b000001000,
    ST_DOWN  = 9'b000010000,
    ST_STOP  = 9'b000100000,
    ST_OFF   = 9'b001000000,
    ST_ALARM = 9'b010000000,
    ST_FILL  = 9'b100000000
  } state_t;

  // Live configuration, pauses already scaled to ticks.
  typedef struct packed {
    logic [FreqW-1:0]  freq_min;
    logic [FreqW-1:0]  freq_max;
    logic [CountW-1:0] pump_count;
    logic [TicksW-1:0] pause_up_ticks;
    logic [TicksW-1:0] pause_down_ticks;
    logic              handover_mode;
    logic              fill_enable;
  } cfg_t;

  // One control tick.
  typedef struct packed {
    logic [TimeW-1:0]  now;
    logic              run_request;
    logic              inverter_fault;
    logic [FreqW-1:0]  inverter_freq;
    logic [TrendW-1:0] limit_trend;
    logic [FreqW-1:0]  pid_freq;
    logic [FillW-1:0]  fill_status;
  } item_t;

  // One result.
  typedef struct packed {
    logic [FreqW-1:0]  freq_task;
    logic [CountW-1:0] pumps_on;
    logic [CodeW-1:0]  ctrl_code;
    logic              pid_clear;
    logic              pid_preset;
    logic              pid_advance;
    logic              pid_slow;
    logic              fill_start;
  } result_t;

  // Maps the one-hot state to its external code.
  function automatic logic [CodeW-1:0] state_code(input state_t st);
    logic [CodeW-1:0] code;
    unique case (st)
      ST_START: code = CODE_START;
      ST_RUN:   code = CODE_RUN;
      ST_UP:    code = CODE_UP;
      ST_DOWN:  code = CODE_DOWN;
      ST_STOP:  code = CODE_STOP;
      ST_OFF:   code = CODE_OFF;
      ST_ALARM: code = CODE_ALARM;
      ST_FILL:  code = CODE_FILL;
      default:  code = CODE_INIT;
    endcase
    return code;
  endfunction

endpackage

/* sv/pcs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Pump cascade configuration registers
// Holds the seven setup registers; pause values are stored scaled to ticks.
// ----------------------------------------------------------------------------
module pcs_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pcs_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [pcs_pkg::CfgDatW-1:0] cfg_data,
  output pcs_pkg::cfg_t               cfg
);

  logic [pcs_pkg::TicksW-1:0] pause_ticks;

  // Writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  // Scale a written pause to ticks once, at write time.
  assign pause_ticks = pcs_pkg::TicksW'(cfg_data) * pcs_pkg::TicksPerPause;

  // Register file; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.freq_min         <= pcs_pkg::FreqMinReset;
      cfg.freq_max         <= pcs_pkg::FreqMaxReset;
      cfg.pump_count       <= pcs_pkg::PumpCountReset;
      cfg.pause_up_ticks   <= pcs_pkg::PauseTicksReset;
      cfg.pause_down_ticks <= pcs_pkg::PauseTicksReset;
      cfg.handover_mode    <= 1'b0;
      cfg.fill_enable      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pcs_pkg::CFG_FREQ_MIN:      cfg.freq_min <= cfg_data[pcs_pkg::FreqW-1:0];
        pcs_pkg::CFG_FREQ_MAX:      cfg.freq_max <= cfg_data[pcs_pkg::FreqW-1:0];
        pcs_pkg::CFG_PUMP_COUNT:    cfg.pump_count <= cfg_data[pcs_pkg::CountW-1:0];
        pcs_pkg::CFG_PAUSE_UP:      cfg.pause_up_ticks <= pause_ticks;
        pcs_pkg::CFG_PAUSE_DOWN:    cfg.pause_down_ticks <= pause_ticks;
        pcs_pkg::CFG_HANDOVER_MODE: cfg.handover_mode <= cfg_data[0];
        pcs_pkg::CFG_FILL_ENABLE:   cfg.fill_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/pcs_step.sv */
// ----------------------------------------------------------------------------
// Pump cascade step logic
// Controller state registers and the next-state logic for one control tick.
// ----------------------------------------------------------------------------
module pcs_step #(
  parameter int MAX_PUMPS = pcs_pkg::MaxPumpsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step_en,
  input  pcs_pkg::item_t   item,
  input  pcs_pkg::cfg_t    cfg,
  output pcs_pkg::result_t result
);

  pcs_pkg::state_t                 state, state_next, state_eff;
  logic [pcs_pkg::CountW-1:0]      stage_count, stage_count_next;
  logic [pcs_pkg::TimeW-1:0]       pause_deadline, pause_deadline_next;
  logic [pcs_pkg::TimeW-1:0]       steady_since, steady_since_next;
  logic [pcs_pkg::FreqW-1:0]       freq_command, freq_command_next;
  logic                            slow_period, slow_period_next;
  logic                            clr, pre, adv, fst;
  logic [pcs_pkg::CountW-1:0]      stage_limit;
  logic [pcs_pkg::TicksW-1:0]      up_wait;
  logic [pcs_pkg::TimeW-1:0]       down_hold_end, up_hold_end;
  logic                            multi_pump;

  // Saturation point for the pump count.
  assign stage_limit = (cfg.pump_count < pcs_pkg::CountW'(MAX_PUMPS)) ?
                       cfg.pump_count : pcs_pkg::CountW'(MAX_PUMPS);
  assign multi_pump  = cfg.pump_count > pcs_pkg::CountW'(1);
  assign up_wait     = multi_pump ? cfg.pause_up_ticks : pcs_pkg::SingleUpWait;

  // Ends of the steady-trend hold windows, wrapping at 32 bits.
  assign down_hold_end = steady_since + pcs_pkg::TimeW'(cfg.pause_down_ticks);
  assign up_hold_end   = steady_since + pcs_pkg::TimeW'(cfg.pause_up_ticks);

  // A fault overrides the current state before it is handled.
  assign state_eff = item.inverter_fault ? pcs_pkg::ST_ALARM : state;

  // Next-state logic for one tick.
  always_comb begin
    state_next          = state_eff;
    stage_count_next    = stage_count;
    pause_deadline_next = pause_deadline;
    steady_since_next   = steady_since;
    freq_command_next   = freq_command;
    slow_period_next    = slow_period;
    clr = 1'b0;
    pre = 1'b0;
    adv = 1'b0;
    fst = 1'b0;
    unique case (state_eff)
      pcs_pkg::ST_START: begin
        if (item.run_request) begin
          freq_command_next = cfg.freq_min;
          if (item.inverter_freq >= cfg.freq_min) begin
            pre = 1'b1;
            pause_deadline_next = item.now;
            if (cfg.fill_enable) begin
              state_next       = pcs_pkg::ST_FILL;
              slow_period_next = 1'b1;
              fst              = 1'b1;
            end else begin
              state_next = pcs_pkg::ST_RUN;
            end
          end
        end else begin
          state_next = pcs_pkg::ST_STOP;
        end
      end
      pcs_pkg::ST_DOWN: begin
        if (cfg.handover_mode) begin
          freq_command_next = cfg.freq_max;
          if (item.inverter_freq >= cfg.freq_max) begin
            state_next = pcs_pkg::ST_RUN;
            pre = 1'b1;
          end
        end else begin
          state_next = pcs_pkg::ST_RUN;
          pause_deadline_next = item.now + pcs_pkg::TimeW'(cfg.pause_down_ticks);
        end
      end
      pcs_pkg::ST_UP: begin
        if (cfg.handover_mode) begin
          freq_command_next = cfg.freq_min;
          if (item.inverter_freq <= cfg.freq_min) begin
            state_next = pcs_pkg::ST_RUN;
            pre = 1'b1;
          end
        end else begin
          state_next = pcs_pkg::ST_RUN;
          pause_deadline_next = item.now + pcs_pkg::TimeW'(up_wait);
        end
      end
      pcs_pkg::ST_RUN: begin
        if (!item.run_request) begin
          state_next = pcs_pkg::ST_STOP;
        end else begin
          adv = 1'b1;
          freq_command_next = item.pid_freq;
          if (pause_deadline < item.now) begin
            if (item.limit_trend == pcs_pkg::TrendDown) begin
              // Remove a pump once the hold has passed and one is on.
              if (!(multi_pump && down_hold_end > item.now) &&
                  stage_count != '0) begin
                stage_count_next    = stage_count - pcs_pkg::CountW'(1);
                state_next          = pcs_pkg::ST_DOWN;
                pause_deadline_next = item.now;
              end
            end else if (item.limit_trend == pcs_pkg::TrendUp) begin
              // Add a pump once the hold has passed and the limit allows.
              if (!(up_hold_end > item.now) && stage_count < stage_limit) begin
                stage_count_next    = stage_count + pcs_pkg::CountW'(1);
                state_next          = pcs_pkg::ST_UP;
                pause_deadline_next = item.now;
              end
            end else begin
              steady_since_next = item.now;
            end
          end
        end
      end
      pcs_pkg::ST_STOP: begin
        if (!item.run_request) begin
          freq_command_next = '0;
          stage_count_next  = '0;
          if (item.inverter_freq == '0) begin
            state_next = pcs_pkg::ST_OFF;
          end
        end else begin
          state_next = pcs_pkg::ST_INIT;
        end
      end
      pcs_pkg::ST_OFF: begin
        if (item.run_request) begin
          state_next = pcs_pkg::ST_INIT;
        end
      end
      pcs_pkg::ST_ALARM: begin
        if (!item.inverter_fault) begin
          state_next = pcs_pkg::ST_OFF;
        end
        stage_count_next = '0;
      end
      pcs_pkg::ST_FILL: begin
        if (item.fill_status[pcs_pkg::FillAlarmBit]) begin
          state_next = pcs_pkg::ST_ALARM;
        end
        if (item.fill_status == pcs_pkg::FillDone) begin
          state_next       = pcs_pkg::ST_RUN;
          slow_period_next = 1'b0;
        end
      end
      default: begin
        slow_period_next = 1'b0;
        clr              = 1'b1;
        stage_count_next = '0;
        state_next       = pcs_pkg::ST_START;
      end
    endcase
  end

  // Result of this tick, taken by the output register.
  always_comb begin
    result.freq_task   = freq_command_next;
    result.pumps_on    = stage_count_next;
    result.ctrl_code   = pcs_pkg::state_code(state_next);
    result.pid_clear   = clr;
    result.pid_preset  = pre;
    result.pid_advance = adv;
    result.pid_slow    = slow_period_next;
    result.fill_start  = fst;
  end

  // Controller state, updated once per processed tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= pcs_pkg::ST_INIT;
      stage_count    <= '0;
      pause_deadline <= '0;
      steady_since   <= '0;
      freq_command   <= '0;
      slow_period    <= 1'b0;
    end else if (step_en) begin
      state          <= state_next;
      stage_count    <= stage_count_next;
      pause_deadline <= pause_deadline_next;
      steady_since   <= steady_since_next;
      freq_command   <= freq_command_next;
      slow_period    <= slow_period_next;
    end
  end

endmodule

/* sv/pump_cascade_stage_sequencer.sv */
// ----------------------------------------------------------------------------
// Pump cascade stage sequencer
// Per-tick controller for a variable speed main pump and extra fixed pumps.
// ----------------------------------------------------------------------------
// Usage:
//   One control tick enters on the input channel (in_valid / in_stall) and
//   one result leaves on the output channel (out_valid / out_stall). A
//   transfer happens at a rising edge with valid high and stall low.
//   Setup registers are written over cfg_valid / cfg_ready with cfg_index
//   and cfg_data; cfg_ready is always high. Write them only while idle.
//   The tick is captured in an input register, the step logic runs between
//   that register and the result register, and the result is shown from
//   the result register. Throughput is one tick per cycle while out_stall
//   is low, set by the single pass from input register to result register.
//   When the receiver stalls, the result is held, one more tick may enter
//   the input register, and then in_stall rises until the result moves.
//   Reset (rst, synchronous) empties both registers, loads the setup
//   defaults and puts the controller in its init state.
// ----------------------------------------------------------------------------
module pump_cascade_stage_sequencer #(
  parameter int MAX_PUMPS = pcs_pkg::MaxPumpsDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  // Input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pcs_pkg::TimeW-1:0]   now,
  input  logic                        run_request,
  input  logic                        inverter_fault,
  input  logic [pcs_pkg::FreqW-1:0]   inverter_freq,
  input  logic signed [pcs_pkg::TrendW-1:0] limit_trend,
  input  logic [pcs_pkg::FreqW-1:0]   pid_freq,
  input  logic [pcs_pkg::FillW-1:0]   fill_status,
  // Output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pcs_pkg::FreqW-1:0]   freq_task,
  output logic [pcs_pkg::CountW-1:0]  pumps_on,
  output logic [pcs_pkg::CodeW-1:0]   ctrl_code,
  output logic                        pid_clear,
  output logic                        pid_preset,
  output logic                        pid_advance,
  output logic                        pid_slow,
  output logic                        fill_start,
  // Configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pcs_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [pcs_pkg::CfgDatW-1:0] cfg_data
);

  pcs_pkg::cfg_t    cfg;
  pcs_pkg::item_t   item;
  pcs_pkg::result_t step_result, result;
  logic             item_valid;
  logic             result_move;
  logic             step_en;

  pcs_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The result register can load when empty or when its result transfers.
  assign result_move = !out_valid || !out_stall;
  assign step_en     = item_valid && result_move;
  assign in_stall    = item_valid && !result_move;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.now            <= now;
      item.run_request    <= run_request;
      item.inverter_fault <= inverter_fault;
      item.inverter_freq  <= inverter_freq;
      item.limit_trend    <= limit_trend;
      item.pid_freq       <= pid_freq;
      item.fill_status    <= fill_status;
    end
  end

  pcs_step #(
    .MAX_PUMPS (MAX_PUMPS)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .item    (item),
    .cfg     (cfg),
    .result  (step_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_move) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      result <= step_result;
    end
  end

  assign freq_task   = result.freq_task;
  assign pumps_on    = result.pumps_on;
  assign ctrl_code   = result.ctrl_code;
  assign pid_clear   = result.pid_clear;
  assign pid_preset  = result.pid_preset;
  assign pid_advance = result.pid_advance;
  assign pid_slow    = result.pid_slow;
  assign fill_start  = result.fill_start;

endmodule

/* sv/pcs_checker.sv */
// ----------------------------------------------------------------------------
// Pump cascade sequencer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pcs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [pcs_pkg::FreqW-1:0]  freq_task,
  input logic [pcs_pkg::CountW-1:0] pumps_on,
  input logic [pcs_pkg::CodeW-1:0]  ctrl_code,
  input logic                       pid_clear,
  input logic                       pid_advance,
  input logic                       pid_slow,
  input logic                       fill_start
);

  // A stalled result stays put until it transfers.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(freq_task) &&
      $stable(pumps_on) && $stable(ctrl_code))
    else $error("stalled result changed");

  // The PID computes only while running or switching a pump.
  a_advance_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && pid_advance |-> ctrl_code == pcs_pkg::CODE_RUN ||
      ctrl_code == pcs_pkg::CODE_UP || ctrl_code == pcs_pkg::CODE_DOWN)
    else $error("pid_advance outside running states");

  // Leaving init clears the pumps and the slow period.
  a_clear_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && pid_clear |-> ctrl_code == pcs_pkg::CODE_START &&
      pumps_on == '0 && !pid_slow)
    else $error("pid_clear with wrong state");

  // Tube fill starts with the slow PID period selected.
  a_fill_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && fill_start |-> ctrl_code == pcs_pkg::CODE_FILL && pid_slow)
    else $error("fill_start with wrong state");

  // No extra pump stays on in alarm.
  a_alarm_pumps: assert property (@(posedge clk) disable iff (rst)
    out_valid && ctrl_code == pcs_pkg::CODE_ALARM |-> pumps_on == '0)
    else $error("pumps on in alarm");

endmodule

bind pump_cascade_stage_sequencer pcs_checker u_pcs_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .freq_task   (freq_task),
  .pumps_on    (pumps_on),
  .ctrl_code   (ctrl_code),
  .pid_clear   (pid_clear),
  .pid_advance (pid_advance),
  .pid_slow    (pid_slow),
  .fill_start  (fill_start)
);

/* tb/sv/tb_pump_cascade_stage_sequencer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pump cascade stage sequencer bench
// Drives control ticks and setup writes into the sequencer and checks every
// result against a cycle-free model of the controller. Both channels idle
// and stall at random. One stretch holds the result side off long enough
// to fill the block. The last stretch runs with no idling at all.
// ----------------------------------------------------------------------------
module tb_pump_cascade_stage_sequencer;
  import pcs_pkg::*;

  localparam int MaxPumps      = MaxPumpsDefault;
  localparam int CycleLimit    = 400000;
  localparam int HoldCycles    = 60;
  localparam int LatencyCycles = 4;
  localparam int ShownFailures = 10;

  // Trend patterns the package does not name; both count as steady.
  localparam logic [TrendW-1:0] TrendSteady = 2'b00;
  localparam logic [TrendW-1:0] TrendOdd    = 2'b10;
  // Register index past the last register; a write to it is ignored.
  localparam logic [CfgIdxW-1:0] CfgUnused  = 3'd7;

  // Clock, reset and block ports.
  logic clk;
  logic rst = 1'b1;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [TimeW-1:0]          now = '0;
  logic                      run_request = 1'b0;
  logic                      inverter_fault = 1'b0;
  logic [FreqW-1:0]          inverter_freq = '0;
  logic signed [TrendW-1:0]  limit_trend = '0;
  logic [FreqW-1:0]          pid_freq = '0;
  logic [FillW-1:0]          fill_status = '0;

  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [FreqW-1:0]          freq_task;
  logic [CountW-1:0]         pumps_on;
  logic [CodeW-1:0]          ctrl_code;
  logic                      pid_clear;
  logic                      pid_preset;
  logic                      pid_advance;
  logic                      pid_slow;
  logic                      fill_start;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CfgIdxW-1:0]        cfg_index = '0;
  logic [CfgDatW-1:0]        cfg_data = '0;

  pump_cascade_stage_sequencer #(
    .MAX_PUMPS(MaxPumps)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .now(now),
    .run_request(run_request),
    .inverter_fault(inverter_fault),
    .inverter_freq(inverter_freq),
    .limit_trend(limit_trend),
    .pid_freq(pid_freq),
    .fill_status(fill_status),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .freq_task(freq_task),
    .pumps_on(pumps_on),
    .ctrl_code(ctrl_code),
    .pid_clear(pid_clear),
    .pid_preset(pid_preset),
    .pid_advance(pid_advance),
    .pid_slow(pid_slow),
    .fill_start(fill_start),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Model copy of the setup registers, loaded with the reset defaults.
  logic [FreqW-1:0]   c_freq_min   = FreqMinReset;
  logic [FreqW-1:0]   c_freq_max   = FreqMaxReset;
  logic [CountW-1:0]  c_pump_count = PumpCountReset;
  logic [PauseW-1:0]  c_pause_up   = PauseW'(50);
  logic [PauseW-1:0]  c_pause_down = PauseW'(50);
  logic               c_handover   = 1'b0;
  logic               c_fill_en    = 1'b0;

  // Model copy of the controller state.
  logic [CodeW-1:0]   m_state    = CODE_INIT;
  logic [CountW-1:0]  m_stages   = '0;
  logic [TimeW-1:0]   m_deadline = '0;
  logic [TimeW-1:0]   m_steady   = '0;
  logic [FreqW-1:0]   m_freq     = '0;
  logic               m_slow     = 1'b0;

  // Results still owed by the block, oldest first.
  result_t step_results[$];

  // Stimulus knobs shared by the driving processes.
  logic        sender_gaps     = 1'b0;
  logic        receiver_bursts = 1'b0;
  logic        long_hold       = 1'b0;
  int unsigned trend_up_pct    = 0;
  logic [TimeW-1:0] tick_now   = '0;
  logic        run_cmd         = 1'b1;
  logic        fault_cmd       = 1'b0;

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  // Free running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter that ends a run which has hung.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // One controller step: updates the model state and returns the result.
  function automatic result_t sequencer_step(input item_t tk);
    result_t          r;
    logic [TimeW-1:0] up_ticks;
    logic [TimeW-1:0] down_ticks;
    logic [TimeW-1:0] wait_ticks;
    logic [CountW-1:0] stage_cap;
    r = '0;
    up_ticks   = TimeW'(c_pause_up) * TimeW'(TicksPerPause);
    down_ticks = TimeW'(c_pause_down) * TimeW'(TicksPerPause);
    stage_cap  = (c_pump_count < CountW'(MaxPumps)) ? c_pump_count : CountW'(MaxPumps);

    // An inverter fault overrides whatever state the controller is in.
    if (tk.inverter_fault) m_state = CODE_ALARM;

    case (m_state)
      CODE_START: begin
        if (tk.run_request) begin
          m_freq = c_freq_min;
          if (tk.inverter_freq >= c_freq_min) begin
            r.pid_preset = 1'b1;
            m_deadline = tk.now;
            if (c_fill_en) begin
              m_state = CODE_FILL;
              m_slow = 1'b1;
              r.fill_start = 1'b1;
            end else begin
              m_state = CODE_RUN;
            end
          end
        end else begin
          m_state = CODE_STOP;
        end
      end
      CODE_DOWN: begin
        if (c_handover) begin
          m_freq = c_freq_max;
          if (tk.inverter_freq >= c_freq_max) begin
            m_state = CODE_RUN;
            r.pid_preset = 1'b1;
          end
        end else begin
          m_state = CODE_RUN;
          m_deadline = TimeW'(down_ticks + tk.now);
        end
      end
      CODE_UP: begin
        if (c_handover) begin
          m_freq = c_freq_min;
          if (tk.inverter_freq <= c_freq_min) begin
            m_state = CODE_RUN;
            r.pid_preset = 1'b1;
          end
        end else begin
          m_state = CODE_RUN;
          wait_ticks = (c_pump_count > CountW'(1)) ? up_ticks : TimeW'(SingleUpWait);
          m_deadline = TimeW'(wait_ticks + tk.now);
        end
      end
      CODE_RUN: begin
        if (!tk.run_request) begin
          m_state = CODE_STOP;
        end else begin
          r.pid_advance = 1'b1;
          m_freq = tk.pid_freq;
          if (m_deadline < tk.now) begin
            if (tk.limit_trend == TrendDown) begin
              // Remove a pump once the down pause has run out.
              if (!(c_pump_count > CountW'(1) && TimeW'(m_steady + down_ticks) > tk.now)
                  && m_stages != '0) begin
                m_stages = m_stages - 1'b1;
                m_state = CODE_DOWN;
                m_deadline = tk.now;
              end
            end else if (tk.limit_trend == TrendUp) begin
              // Add a pump once the up pause has run out, up to the cap.
              if (!(TimeW'(m_steady + up_ticks) > tk.now) && m_stages < stage_cap) begin
                m_stages = m_stages + 1'b1;
                m_state = CODE_UP;
                m_deadline = tk.now;
              end
            end else begin
              m_steady = tk.now;
            end
          end
        end
      end
      CODE_STOP: begin
        if (!tk.run_request) begin
          m_freq = '0;
          m_stages = '0;
          if (tk.inverter_freq == '0) m_state = CODE_OFF;
        end else begin
          m_state = CODE_INIT;
        end
      end
      CODE_OFF: begin
        if (tk.run_request) m_state = CODE_INIT;
      end
      CODE_ALARM: begin
        if (!tk.inverter_fault) m_state = CODE_OFF;
        m_stages = '0;
      end
      CODE_FILL: begin
        if (tk.fill_status[FillAlarmBit]) m_state = CODE_ALARM;
        if (tk.fill_status == FillDone) begin
          m_state = CODE_RUN;
          m_slow = 1'b0;
        end
      end
      default: begin
        m_slow = 1'b0;
        r.pid_clear = 1'b1;
        m_stages = '0;
        m_state = CODE_START;
      end
    endcase

    r.freq_task = m_freq;
    r.pumps_on  = m_stages;
    r.ctrl_code = m_state;
    r.pid_slow  = m_slow;
    return r;
  endfunction

  // Builds one tick from its field values.
  function automatic item_t make_tick(input logic [TimeW-1:0] t, input logic run,
                                      input logic flt, input logic [FreqW-1:0] inv,
                                      input logic [TrendW-1:0] trend,
                                      input logic [FreqW-1:0] pid,
                                      input logic [FillW-1:0] fill);
    item_t tk;
    tk.now            = t;
    tk.run_request    = run;
    tk.inverter_fault = flt;
    tk.inverter_freq  = inv;
    tk.limit_trend    = trend;
    tk.pid_freq       = pid;
    tk.fill_status    = fill;
    return tk;
  endfunction

  // Mostly plausible ticks: time moves forward, run and fault are sticky,
  // frequencies sit on the thresholds often. A share is pure noise.
  function automatic item_t random_tick();
    item_t       tk;
    int unsigned pick;
    if ($urandom_range(0, 99) < 10) begin
      tk = make_tick($urandom, 1'($urandom), 1'($urandom), FreqW'($urandom),
                     TrendW'($urandom), FreqW'($urandom), FillW'($urandom));
      return tk;
    end

    // Advance the timer, with jumps, back steps and the wrap point.
    pick = $urandom_range(0, 99);
    if (pick < 70) tick_now = tick_now + $urandom_range(1, 300);
    else if (pick < 80) tick_now = tick_now + $urandom_range(0, 1 << 20);
    else if (pick < 85) tick_now = $urandom;
    else if (pick < 90) tick_now = 32'hFFFF_FFFF - $urandom_range(0, 500);

    if ($urandom_range(0, 99) < 3) run_cmd = ~run_cmd;
    if (fault_cmd) fault_cmd = 1'($urandom_range(0, 1));
    else fault_cmd = ($urandom_range(0, 99) < 2);

    tk.now            = tick_now;
    tk.run_request    = run_cmd;
    tk.inverter_fault = fault_cmd;

    case ($urandom_range(0, 9))
      0: tk.inverter_freq = '0;
      1: tk.inverter_freq = c_freq_min;
      2: tk.inverter_freq = c_freq_max;
      3: tk.inverter_freq = c_freq_min - 1'b1;
      4: tk.inverter_freq = c_freq_max + 1'b1;
      default: tk.inverter_freq = FreqW'($urandom);
    endcase

    if ($urandom_range(0, 99) < trend_up_pct) tk.limit_trend = TrendUp;
    else tk.limit_trend = TrendW'($urandom);

    tk.pid_freq = FreqW'($urandom);

    pick = $urandom_range(0, 9);
    if (pick < 5) tk.fill_status = '0;
    else if (pick < 7) tk.fill_status = FillDone;
    else if (pick < 8) tk.fill_status = {1'b1, 7'($urandom)};
    else tk.fill_status = FillW'($urandom);
    return tk;
  endfunction

  // Offers one tick and waits for its transfer, then books its result.
  task automatic send_tick(input item_t tk);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    now            <= tk.now;
    run_request    <= tk.run_request;
    inverter_fault <= tk.inverter_fault;
    inverter_freq  <= tk.inverter_freq;
    limit_trend    <= tk.limit_trend;
    pid_freq       <= tk.pid_freq;
    fill_status    <= tk.fill_status;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_results.push_back(sequencer_step(tk));
  endtask

  // Stops offering ticks until every booked result has come out.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (step_results.size() != 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);
  endtask

  // Writes all setup registers, plus the unused index, while idle.
  task automatic apply_settings(input int unsigned fmin, input int unsigned fmax,
                                input int unsigned pumps, input int unsigned up_pause,
                                input int unsigned down_pause, input int unsigned ho,
                                input int unsigned fe);
    logic [CfgDatW-1:0] vals[8];
    wait_results_done();
    vals[CFG_FREQ_MIN]      = CfgDatW'(fmin);
    vals[CFG_FREQ_MAX]      = CfgDatW'(fmax);
    vals[CFG_PUMP_COUNT]    = CfgDatW'(pumps);
    vals[CFG_PAUSE_UP]      = CfgDatW'(up_pause);
    vals[CFG_PAUSE_DOWN]    = CfgDatW'(down_pause);
    vals[CFG_HANDOVER_MODE] = CfgDatW'(ho);
    vals[CFG_FILL_ENABLE]   = CfgDatW'(fe);
    vals[CfgUnused]         = CfgDatW'($urandom);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CfgIdxW'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (cfg_index_t'(i))
        CFG_FREQ_MIN:      c_freq_min   = vals[i][FreqW-1:0];
        CFG_FREQ_MAX:      c_freq_max   = vals[i][FreqW-1:0];
        CFG_PUMP_COUNT:    c_pump_count = vals[i][CountW-1:0];
        CFG_PAUSE_UP:      c_pause_up   = vals[i][PauseW-1:0];
        CFG_PAUSE_DOWN:    c_pause_down = vals[i][PauseW-1:0];
        CFG_HANDOVER_MODE: c_handover   = vals[i][0];
        CFG_FILL_ENABLE:   c_fill_en    = vals[i][0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Random ticks under the setup that reset leaves behind.
  task automatic phase_reset_defaults();
    repeat (150) send_tick(random_tick());
  endtask

  // Walks every state and the main transitions, with the field extremes.
  task automatic phase_directed_paths();
    apply_settings(250, 500, 15, 0, 0, 0, 1);
    // Start into tube fill, then a fill alarm ends in alarm and off.
    send_tick(make_tick(32'd10, 1'b1, 1'b0, 12'd0, TrendSteady, 12'd0, 8'd0));
    send_tick(make_tick(32'd20, 1'b1, 1'b0, 12'hFFF, TrendSteady, 12'd0, 8'd0));
    send_tick(make_tick(32'd30, 1'b1, 1'b0, 12'd0, TrendSteady, 12'd0, 8'h80));
    send_tick(make_tick(32'd40, 1'b1, 1'b0, 12'd0, TrendSteady, 12'd0, 8'h00));
    send_tick(make_tick(32'd50, 1'b1, 1'b0, 12'd0, TrendSteady, 12'd0, 8'hFF));
    // Start on the exact lower frequency, then fill done goes to run.
    send_tick(make_tick(32'd60, 1'b1, 1'b0, 12'd0, TrendSteady, 12'd0, 8'd0));
    send_tick(make_tick(32'd70, 1'b1, 1'b0, 12'd250, TrendSteady, 12'd0, 8'd0));
    send_tick(make_tick(32'd80, 1'b1, 1'b0, 12'd0, TrendSteady, 12'd0, FillDone));
    // The unused trend pattern counts as steady.
    send_tick(make_tick(32'd100, 1'b1, 1'b0, 12'd0, TrendOdd, 12'hFFF, 8'd0));
    // Add one pump, return to run, then remove it again.
    send_tick(make_tick(32'd200, 1'b1, 1'b0, 12'd0, TrendUp, 12'd0, 8'd0));
    send_tick(make_tick(32'd210, 1'b1, 1'b0, 12'd0, TrendSteady, 12'hFFF, 8'd0));
    send_tick(make_tick(32'd400, 1'b1, 1'b0, 12'd0, TrendDown, 12'd0, 8'd0));
    send_tick(make_tick(32'd410, 1'b1, 1'b0, 12'd0, TrendSteady, 12'hFFF, 8'd0));
    // Stop waits for the inverter to reach zero before off.
    send_tick(make_tick(32'd420, 1'b0, 1'b0, 12'd0, TrendSteady, 12'd0, 8'd0));
    send_tick(make_tick(32'd430, 1'b0, 1'b0, 12'd5, TrendSteady, 12'd0, 8'd0));
    send_tick(make_tick(32'd440, 1'b0, 1'b0, 12'd0, TrendSteady, 12'd0, 8'd0));
    send_tick(make_tick(32'd450, 1'b1, 1'b0, 12'd0, TrendSteady, 12'd0, 8'd0));
    // A fault forces alarm until it clears.
    send_tick(make_tick(32'd460, 1'b1, 1'b1, 12'd0, TrendSteady, 12'd0, 8'd0));
    send_tick(make_tick(32'd470, 1'b1, 1'b1, 12'd0, TrendSteady, 12'd0, 8'd0));
    send_tick(make_tick(32'd480, 1'b1, 1'b0, 12'd0, TrendSteady, 12'd0, 8'd0));
    // Timer extremes, and a start with run dropped goes to stop.
    send_tick(make_tick(32'hFFFF_FFFF, 1'b1, 1'b0, 12'd0, TrendSteady, 12'd0, 8'd0));
    send_tick(make_tick(32'd0, 1'b1, 1'b0, 12'd0, TrendSteady, 12'd0, 8'd0));
    send_tick(make_tick(32'd5, 1'b0, 1'b0, 12'd0, TrendSteady, 12'd0, 8'd0));
  endtask

  // Several setups, extremes first, then random ones with short pauses.
  task automatic phase_random_settings();
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_settings(250, 500, 2, 1, 1, 0, 0);
        1: apply_settings(0, 4095, 15, 0, 0, 1, 1);
        2: apply_settings(4095, 0, 0, 8191, 8191, 0, 1);
        3: apply_settings(100, 3000, 1, 2, 3, 0, 0);
        default: apply_settings($urandom_range(0, 4095), $urandom_range(0, 4095),
                                $urandom_range(0, 15), $urandom_range(0, 4),
                                $urandom_range(0, 4), $urandom_range(0, 1),
                                $urandom_range(0, 1));
      endcase
      // Lean on the up trend in some setups so the pump cap is reached.
      trend_up_pct = (p == 1 || p == 5) ? 60 : 0;
      repeat (180) send_tick(random_tick());
    end
    trend_up_pct = 0;
  endtask

  // The result side holds off while ticks keep coming, then the sender waits.
  task automatic phase_backpressure();
    long_hold = 1'b1;
    repeat (30) send_tick(random_tick());
    wait_results_done();
  endtask

  // Final stretch with both sides always ready.
  task automatic phase_unbroken_stream();
    sender_gaps = 1'b0;
    receiver_bursts = 1'b0;
    apply_settings(300, 1200, 4, 1, 1, 1, 1);
    repeat (150) send_tick(random_tick());
  endtask

  // Result side: random stall bursts and the one long hold.
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (receiver_bursts && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compares each result transfer with the oldest booked result.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{freq_task, pumps_on, ctrl_code, pid_clear, pid_preset, pid_advance,
              pid_slow, fill_start};
      if (step_results.size() == 0) begin
        fail_count++;
        if (fail_count <= ShownFailures)
          $display("[%0t] result with none outstanding: code=%0d", $realtime, ctrl_code);
      end else begin
        want = step_results.pop_front();
        if (got.freq_task !== want.freq_task || got.pumps_on !== want.pumps_on ||
            got.ctrl_code !== want.ctrl_code || got.pid_clear !== want.pid_clear ||
            got.pid_preset !== want.pid_preset || got.pid_advance !== want.pid_advance ||
            got.pid_slow !== want.pid_slow || got.fill_start !== want.fill_start) begin
          fail_count++;
          if (fail_count <= ShownFailures) begin
            $display("[%0t] mismatch expected freq=%0d pumps=%0d code=%0d clr=%b pre=%b adv=%b slow=%b fst=%b",
                     $realtime, want.freq_task, want.pumps_on, want.ctrl_code,
                     want.pid_clear, want.pid_preset, want.pid_advance,
                     want.pid_slow, want.fill_start);
            $display("[%0t]          actual freq=%0d pumps=%0d code=%0d clr=%b pre=%b adv=%b slow=%b fst=%b",
                     $realtime, got.freq_task, got.pumps_on, got.ctrl_code,
                     got.pid_clear, got.pid_preset, got.pid_advance,
                     got.pid_slow, got.fill_start);
          end
        end
      end
    end
  end

  // Main sequence.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    sender_gaps = 1'b1;
    receiver_bursts = 1'b1;

    phase_reset_defaults();
    phase_directed_paths();
    phase_random_settings();
    phase_backpressure();
    phase_unbroken_stream();

    wait_results_done();
    if (fail_count == 0 && step_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/pcs_pkg.sv
sv/pcs_cfg_regs.sv
sv/pcs_step.sv
sv/pump_cascade_stage_sequencer.sv
sv/pcs_checker.sv
tb/sv/tb_pump_cascade_stage_sequencer.sv
